// File: design/bsb_pkg.sv
package bsb_pkg;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INIT  = 9'b000000010,
        S_TERM  = 9'b000000100,
        S_RDA   = 9'b000001000,
        S_RDB   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

// File: design/bsb_ram.sv
module bsb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bsb_div.sv
module bsb_div #(
    parameter int NW = 40,
    parameter int DW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output bsb_pkg::t_div_ctl o_ctl
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   n_trial;
    logic [DW:0]   n_shift;

    assign n_shift = {r_rem[DW-1:0], r_quo[NW-1]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!n_trial[DW]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;

endmodule

// File: design/bspline_basis_evaluator.sv
// Cox-de Boor B-spline basis evaluator. A knot write (kind 0) goes from IDLE to DONE,
// and its result is then registered onto o_valid. An evaluate (kind 1) walks the basis
// triangle one term side at a time through a single shared shift-subtract divider and
// one multiplier. A division holds the sequencer in S_DIV until the divider is done. A
// side whose two knots are equal skips the divider, and so does each degree-0 entry.
// start is taken only while busy is low, so a new item waits until the last one is
// through. busy is high while an item is in flight. The result appears for one cycle
// with o_valid high and must be captured then: the receiver cannot stall it.
module bspline_basis_evaluator #(
    parameter int KNOT_DEPTH = 64,
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_kind,
    input  logic [5:0]           i_knot_slot,
    input  logic [FRAC_BITS:0]   i_knot_value,
    input  logic [5:0]           i_basis_index,
    input  logic [2:0]           i_basis_degree,
    input  logic [FRAC_BITS:0]   i_param_t,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_basis_value,
    output logic                 o_status
);

    localparam int AW   = $clog2(KNOT_DEPTH);
    localparam int VW   = FRAC_BITS + 1;
    localparam int DW   = VW + 1;
    localparam int NW   = VW + 1 + FRAC_BITS + 4;
    localparam int NS   = MAX_DEGREE + 2;
    localparam int JW   = $clog2(NS);
    localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;
    localparam logic [VW+2:0] LIM = (VW + 3)'(4) << FRAC_BITS;

    bsb_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_i;
    logic [3:0]      r_k;
    logic [VW-1:0]   r_t;
    logic [JW-1:0]   r_j;
    logic [3:0]      r_d;
    logic            r_side;
    logic [VW-1:0]   r_n [NS];
    logic [VW-1:0]   r_ka;
    logic signed [VW+3:0] r_sum;
    logic [VW+2:0]   r_coef;
    logic            r_neg;
    logic            r_valid;
    logic [VW-1:0]   r_val;
    logic            r_status;
    logic            r_rdsel;
    logic [AW-1:0]   n_raddr;
    logic [VW-1:0]   w_rdata;
    logic            w_div_start;
    logic [NW-1:0]   w_num;
    logic [DW-1:0]   w_den;
    logic [NW-1:0]   w_quo;
    bsb_pkg::t_div_ctl w_div;
    logic [VW-1:0]   r_kb;
    logic [AW-1:0]   w_lo, w_hi;
    logic            w_we;
    logic [2*VW+3:0] w_prod;
    logic [VW+2:0]   w_mag;
    logic [VW-1:0]   w_nsel;
    logic signed [VW+3:0] w_term, w_acc;
    logic signed [VW:0] w_diff, w_dden;

    assign w_we = start && !busy && i_kind == bsb_pkg::KIND_WRITE
                  && 32'(i_knot_slot) < KNOT_DEPTH;

    bsb_ram #(.WIDTH(VW), .DEPTH(KNOT_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AW'(i_knot_slot)),
        .i_wdata(VW'(i_knot_value)),
        .i_raddr(n_raddr),
        .o_rdata(w_rdata)
    );

    // term operand addresses: lo knot and hi knot for each side
    always_comb begin
        if (r_d == 4'd0) begin
            w_lo = r_i + AW'(r_j);
            w_hi = w_lo + AW'(1);
        end else if (!r_side) begin
            w_lo = r_i + AW'(r_j);
            w_hi = w_lo + AW'(r_d);
        end else begin
            w_lo = r_i + AW'(r_j) + AW'(1);
            w_hi = w_lo + AW'(r_d);
        end
        n_raddr = r_rdsel ? w_hi : w_lo;
    end

    // numerator: side 0 t-lo, side 1 hi-t; denominator hi-lo
    always_comb begin
        w_diff = !r_side ? $signed({1'b0, r_t}) - $signed({1'b0, r_ka})
                         : $signed({1'b0, r_kb}) - $signed({1'b0, r_t});
        w_dden = $signed({1'b0, r_kb}) - $signed({1'b0, r_ka});
    end

    logic [VW-1:0] w_absn, w_absd;
    assign w_absn = w_diff[VW] ? VW'(-w_diff) : VW'(w_diff);
    assign w_absd = w_dden[VW] ? VW'(-w_dden) : VW'(w_dden);
    assign w_num  = NW'(w_absn) << FRAC_BITS;
    assign w_den  = DW'(w_absd);

    bsb_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_quo  (w_quo),
        .o_ctl  (w_div)
    );

    assign w_nsel = !r_side ? r_n[r_j[JW-1:0]] : r_n[JW'(r_j + 1'b1)];
    assign w_prod = (2*VW+4)'(r_coef) * (2*VW+4)'(w_nsel);
    assign w_mag  = (VW+3)'(w_prod >> FRAC_BITS);
    assign w_term = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    assign w_acc  = r_sum + w_term;
    assign w_div_start = (r_state == bsb_pkg::S_DIV) && !w_div.busy && !w_div.done
                         && !r_rdsel;

    assign busy = (r_state != bsb_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsb_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_rdsel <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                bsb_pkg::S_IDLE: begin
                    if (start) begin
                        r_val    <= '0;
                        r_status <= bsb_pkg::STATUS_OK;
                        r_i      <= AW'(i_basis_index);
                        r_k      <= 4'(i_basis_degree);
                        r_t      <= VW'(i_param_t);
                        r_j      <= '0;
                        r_d      <= '0;
                        r_side   <= 1'b0;
                        r_rdsel  <= 1'b0;
                        if (i_kind == bsb_pkg::KIND_WRITE) begin
                            r_state <= bsb_pkg::S_DONE;
                        end else if (4'(i_basis_degree) > 4'(MAX_DEGREE) ||
                                     32'(i_basis_index) + 32'(i_basis_degree) + 1
                                     >= KNOT_DEPTH) begin
                            r_status <= bsb_pkg::STATUS_RANGE;
                            r_state  <= bsb_pkg::S_DONE;
                        end else begin
                            r_state <= bsb_pkg::S_INIT;
                        end
                    end
                end
                bsb_pkg::S_INIT: begin
                    r_rdsel <= 1'b1;
                    r_state <= bsb_pkg::S_RDA;
                end
                bsb_pkg::S_RDA: begin
                    r_ka    <= w_rdata;
                    r_state <= bsb_pkg::S_RDB;
                end
                bsb_pkg::S_RDB: begin
                    r_state <= bsb_pkg::S_TERM;
                end
                bsb_pkg::S_TERM: begin
                    r_kb    <= w_rdata;
                    r_rdsel <= 1'b0;
                    if (r_d == 4'd0) begin
                        r_n[r_j[JW-1:0]] <= (r_ka <= r_t && r_t < w_rdata) ? ONE : '0;
                        r_state <= bsb_pkg::S_NEXT;
                    end else if (w_rdata == r_ka) begin
                        r_state <= bsb_pkg::S_NEXT;
                    end else begin
                        r_state <= bsb_pkg::S_DIV;
                    end
                end
                bsb_pkg::S_DIV: begin
                    if (w_div.done) begin
                        r_neg  <= w_diff[VW] ^ w_dden[VW];
                        r_coef <= (w_quo > NW'(LIM)) ? LIM : (VW+3)'(w_quo);
                        r_state <= bsb_pkg::S_MUL;
                    end
                end
                bsb_pkg::S_MUL: begin
                    r_sum   <= w_acc;
                    r_state <= bsb_pkg::S_NEXT;
                end
                bsb_pkg::S_NEXT: begin
                    if (r_d != 4'd0 && !r_side) begin
                        r_side  <= 1'b1;
                        r_state <= bsb_pkg::S_INIT;
                    end else begin
                        if (r_d != 4'd0) begin
                            r_n[r_j[JW-1:0]] <= r_sum < 0 ? '0
                                : (r_sum > $signed({4'b0, ONE}) ? ONE : VW'(r_sum));
                        end
                        r_side <= 1'b0;
                        r_sum  <= '0;
                        if (4'(r_j) + r_d < r_k) begin
                            r_j     <= r_j + 1'b1;
                            r_state <= bsb_pkg::S_INIT;
                        end else if (r_d < r_k) begin
                            r_d     <= r_d + 4'd1;
                            r_j     <= '0;
                            r_state <= bsb_pkg::S_INIT;
                        end else begin
                            r_state <= bsb_pkg::S_DONE;
                        end
                    end
                end
                bsb_pkg::S_DONE: begin
                    if (r_status == bsb_pkg::STATUS_OK && r_k != 4'd0 || r_d != 4'd0) begin
                        r_val <= (r_status == bsb_pkg::STATUS_OK) ? r_n[0] : '0;
                    end else if (r_status == bsb_pkg::STATUS_OK) begin
                        r_val <= r_n[0];
                    end
                    r_valid <= 1'b1;
                    r_state <= bsb_pkg::S_IDLE;
                end
                default: r_state <= bsb_pkg::S_IDLE;
            endcase
            if (r_state == bsb_pkg::S_IDLE && start && i_kind == bsb_pkg::KIND_WRITE) begin
                r_n[0] <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_basis_value = r_val;
    assign o_status      = r_status;

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !$past(r_state == bsb_pkg::S_IDLE) || $past(!i_rst_n))
        else $error("result without work");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status |-> r_val == '0) else $error("error result not zero");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int      TABLE_DEPTH = 64;
    localparam longint  ONE_Q       = 64'sd65536;
    localparam longint  COEF_MAX    = 4 * ONE_Q;
    localparam int      CYCLE_LIMIT = 10_000_000;

    typedef struct {
        logic [16:0] value;
        logic        status;
    } t_basis_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        i_kind         = bsb_pkg::KIND_WRITE;
    logic [5:0]  i_knot_slot    = '0;
    logic [16:0] i_knot_value   = '0;
    logic [5:0]  i_basis_index  = '0;
    logic [2:0]  i_basis_degree = '0;
    logic [16:0] i_param_t      = '0;
    logic        busy;
    logic        o_valid;
    logic [16:0] o_basis_value;
    logic        o_status;

    logic [16:0]   knots [TABLE_DEPTH];
    t_basis_result pending_results [$];
    int            gap_percent = 0;
    int            error_count = 0;
    int            cycle_count = 0;
    int            write_count = 0;
    int            eval_count  = 0;
    int            range_count = 0;
    int            result_count = 0;

    bspline_basis_evaluator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint clamp_q(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint ratio_q(longint num, longint den);
        return clamp_q((num * ONE_Q) / den, -COEF_MAX, COEF_MAX);
    endfunction

    function automatic longint scale_q(longint a, longint b);
        longint p;
        longint mag;
        p   = a * b;
        mag = (p < 0 ? -p : p) >>> 16;
        return p < 0 ? -mag : mag;
    endfunction

    function automatic t_basis_result basis_value_of(int i, int k, longint t);
        t_basis_result r;
        longint n [8];
        longint ka, kad, ka1, kad1, sum;
        r.value  = '0;
        r.status = bsb_pkg::STATUS_OK;
        if (i + k + 1 >= TABLE_DEPTH) begin
            r.status = bsb_pkg::STATUS_RANGE;
            return r;
        end
        for (int j = 0; j <= k; j++)
            n[j] = (knots[i+j] <= t && t < knots[i+j+1]) ? ONE_Q : 0;
        for (int d = 1; d <= k; d++) begin
            for (int j = 0; j + d <= k; j++) begin
                ka   = knots[i+j];
                kad  = knots[i+j+d];
                ka1  = knots[i+j+1];
                kad1 = knots[i+j+d+1];
                sum  = 0;
                if (kad != ka)
                    sum += scale_q(ratio_q(t - ka, kad - ka), n[j]);
                if (kad1 != ka1)
                    sum += scale_q(ratio_q(kad1 - t, kad1 - ka1), n[j+1]);
                n[j] = clamp_q(sum, 0, ONE_Q);
            end
        end
        r.value = n[0][16:0];
        return r;
    endfunction

    // one transaction; start stays high so back-to-back items need no gap
    task automatic send_item(logic kind, int slot, int kval, int idx, int deg, int t);
        t_basis_result r;
        start          <= 1'b1;
        i_kind         <= kind;
        i_knot_slot    <= slot[5:0];
        i_knot_value   <= kval[16:0];
        i_basis_index  <= idx[5:0];
        i_basis_degree <= deg[2:0];
        i_param_t      <= t[16:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == bsb_pkg::KIND_WRITE) begin
            knots[slot] = kval[16:0];
            r.value     = '0;
            r.status    = bsb_pkg::STATUS_OK;
            write_count++;
        end else begin
            r = basis_value_of(idx, deg, t);
            eval_count++;
            if (r.status == bsb_pkg::STATUS_RANGE) range_count++;
        end
        pending_results.push_back(r);
        if ($urandom_range(99) < gap_percent) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_knot(int slot, int kval);
        send_item(bsb_pkg::KIND_WRITE, slot, kval, $urandom_range(63), $urandom_range(7),
                  $urandom_range(65536));
    endtask

    task automatic eval_basis(int idx, int deg, int t);
        send_item(bsb_pkg::KIND_EVAL, $urandom_range(63), $urandom_range(65536), idx, deg, t);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_basis_result e;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result value=%0d status=%0d",
                         $time, o_basis_value, o_status);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_basis_value !== e.value) begin
                    $display("%0t basis value expected %0d actual %0d",
                             $time, e.value, o_basis_value);
                    error_count++;
                end
                if (o_status !== e.status) begin
                    $display("%0t status expected %0d actual %0d",
                             $time, e.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // uniform clamped knot vector over the whole table
    task automatic test_table_load();
        for (int s = 0; s < TABLE_DEPTH; s++)
            write_knot(s, s < 4 ? 0 : (s > 59 ? 65536 : (s - 3) * 1170));
    endtask

    task automatic test_directed();
        eval_basis(0, 0, 0);
        eval_basis(3, 0, 0);
        eval_basis(10, 7, 14000);
        eval_basis(0, 7, 0);
        eval_basis(55, 7, 65535);
        eval_basis(56, 7, 65536);
        eval_basis(63, 0, 1000);
        eval_basis(62, 0, 65536);
        eval_basis(52, 3, 65536);
        // repeated knots give zero-width spans
        write_knot(20, 30000);
        write_knot(21, 30000);
        write_knot(22, 30000);
        eval_basis(18, 4, 30000);
        eval_basis(19, 3, 29999);
        // decreasing knots drive the saturation paths
        write_knot(30, 65536);
        write_knot(31, 0);
        write_knot(32, 40000);
        eval_basis(29, 4, 65536);
        eval_basis(28, 5, 0);
    endtask

    task automatic test_random(int n_items);
        int base, len, kv, sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                // well-formed window: non-decreasing knots then evaluations starting at or just before it
                len  = $urandom_range(2, 10);
                base = $urandom_range(0, TABLE_DEPTH - len);
                kv   = $urandom_range(0, 40000);
                for (int s = 0; s < len; s++) begin
                    if ($urandom_range(3) != 0)
                        kv = kv + $urandom_range(0, 9000);
                    if (kv > 65536) kv = 65536;
                    write_knot(base + s, kv);
                end
                sent += len;
                repeat ($urandom_range(1, 4)) begin
                    eval_basis(base > 3 ? base - $urandom_range(3) : base,
                               $urandom_range(0, 7), $urandom_range(0, 65536));
                    sent++;
                end
            end else begin
                if ($urandom_range(1))
                    write_knot($urandom_range(63), $urandom_range(65536));
                else
                    eval_basis($urandom_range(63), $urandom_range(7), $urandom_range(65536));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_load();
        test_directed();
        gap_percent = 13;
        test_random(130);
        drain_results();
        gap_percent = 67;
        test_random(130);
        gap_percent = 0;
        test_random(130);
        drain_results();
        repeat (50) @(posedge i_clk);
        $display("covered %0d knot writes and %0d evaluations (%0d out of range)",
                 write_count, eval_count, range_count);
        $display("checked %0d results over three sender idling phases", result_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/bsb_pkg.sv
design/bsb_ram.sv
design/bsb_div.sv
design/bspline_basis_evaluator.sv
dv/testbench.sv
